### hdl/ipa_pkg.sv
package ipa_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int STATUS_W  = 2;

    localparam logic [CNT_W-1:0] POOL_SIZE_C = CNT_W'(POOL_SIZE);

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // item taken this cycle
        logic pop_done;  // stack read data is ready, load the result
    } ipa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;    // presented item is an allocate served from the stack
        logic out_full;  // result register occupied and not taken this cycle
    } ipa_sts_t;

endpackage

### hdl/ipa_req_if.sv
interface ipa_req_if
    import ipa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [SLOT_W-1:0] slot_to_free;

    modport source (output valid, output opcode, output slot_to_free, input ready);
    modport sink   (input valid, input opcode, input slot_to_free, output ready);
endinterface

### hdl/ipa_rsp_if.sv
interface ipa_rsp_if
    import ipa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [CNT_W-1:0]    available_count;

    modport source (output valid, output status, output granted_slot,
                    output available_count, input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input available_count, output ready);
endinterface

### hdl/ipa_ctrl.sv
module ipa_ctrl
    import ipa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ipa_sts_t sts,
    output ipa_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready = (state_reg == S_IDLE) && !sts.out_full;

    always_comb
    begin
        cmd.accept   = in_valid && in_ready;
        cmd.pop_done = 1'b0;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && sts.is_pop)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop_done = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/ipa_dp.sv
module ipa_dp
    import ipa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic                opcode,
    input  logic [SLOT_W-1:0]   slot_to_free,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   granted_slot,
    output logic [CNT_W-1:0]    available_count,
    input  ipa_cmd_t            cmd,
    output ipa_sts_t            sts
);

    logic [SLOT_W-1:0] stack_mem [POOL_SIZE];

    logic [CNT_W-1:0]    capacity_reg;
    logic [CNT_W-1:0]    depth_reg;
    logic [CNT_W-1:0]    depth_next;
    logic [CNT_W-1:0]    bump_reg;
    logic [CNT_W-1:0]    bump_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   granted_reg;
    logic [CNT_W-1:0]    avail_reg;
    logic [SLOT_W-1:0]   rd_data_reg;

    logic [CNT_W-1:0]    cap_eff;
    logic [CNT_W-1:0]    rest;
    logic [CNT_W:0]      sum;
    logic [CNT_W-1:0]    avail_next;
    logic                stack_nonempty;
    logic                mem_we;
    logic [STATUS_W-1:0] step_status;
    logic [SLOT_W-1:0]   step_grant;

    assign cap_eff        = (capacity_reg > POOL_SIZE_C) ? POOL_SIZE_C : capacity_reg;
    assign stack_nonempty = (depth_reg != '0);

    assign sts.is_pop   = (opcode == OP_ALLOC) && stack_nonempty;
    assign sts.out_full = out_valid_reg && !out_ready;

    always_comb
    begin
        depth_next  = depth_reg;
        bump_next   = bump_reg;
        mem_we      = 1'b0;
        step_status = ST_OK;
        step_grant  = '0;
        if (cmd.accept)
        begin
            if (opcode == OP_ALLOC)
            begin
                if (stack_nonempty)
                begin
                    depth_next = depth_reg - CNT_W'(1);
                end
                else if (bump_reg < cap_eff)
                begin
                    step_grant = bump_reg[SLOT_W-1:0];
                    bump_next  = bump_reg + CNT_W'(1);
                end
                else
                begin
                    step_status = ST_EMPTY;
                end
            end
            else
            begin
                if (({1'b0, slot_to_free} >= cap_eff) || (depth_reg == POOL_SIZE_C))
                begin
                    step_status = ST_REJECT;
                end
                else
                begin
                    mem_we     = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                end
            end
        end
    end

    // count after the step; depth can pass capacity after double frees
    assign rest       = (cap_eff > bump_next) ? (cap_eff - bump_next) : '0;
    assign sum        = {1'b0, depth_next} + {1'b0, rest};
    assign avail_next = sum[CNT_W] ? '1 : sum[CNT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[depth_reg[SLOT_W-1:0]] <= slot_to_free;
        end
        if (cmd.accept && sts.is_pop)
        begin
            rd_data_reg <= stack_mem[depth_next[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= POOL_SIZE_C;
            depth_reg     <= '0;
            bump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            depth_reg <= depth_next;
            bump_reg  <= bump_next;
            if ((cmd.accept && !sts.is_pop) || cmd.pop_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !sts.is_pop)
        begin
            status_reg  <= step_status;
            granted_reg <= step_grant;
            avail_reg   <= avail_next;
        end
        else if (cmd.pop_done)
        begin
            status_reg  <= ST_OK;
            granted_reg <= rd_data_reg;
            avail_reg   <= avail_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_slot    = granted_reg;
    assign available_count = avail_reg;

endmodule

### hdl/index_pool_allocator.sv
// Slot index allocator. An allocate pops the most recently freed index from a
// LIFO free stack, or hands out the next never-used index while that pointer is
// below the capacity register (held to the pool size); a free pushes an index.
// Frees at or above capacity, or onto a full stack, are rejected and change
// nothing. Each item gives one result with status, granted index and the count
// of slots still available. Items served directly go to the result register;
// a stack pop first reads the stack memory into a register, then loads its
// result in a pop state that takes no new item. The result register lets a
// new item in while the old result is being taken. The user must write
// capacity via cfg_we/cfg_wdata only while the block is idle (not enforced).
module index_pool_allocator
    import ipa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    ipa_req_if.sink          req,
    ipa_rsp_if.source        rsp
);

    ipa_cmd_t cmd;
    ipa_sts_t sts;

    ipa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .opcode          (req.opcode),
        .slot_to_free    (req.slot_to_free),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .status          (rsp.status),
        .granted_slot    (rsp.granted_slot),
        .available_count (rsp.available_count),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
